// File: rtl/core/gsa_pkg.sv
// shared constants, types and helpers of the grain slot allocator
package gsa_pkg;

  localparam int SLOTS       = 64;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int LEN_W       = 20;
  localparam int OUT_SLOT_W  = 6;
  localparam int OUT_CNT_W   = 7;

  localparam logic CMD_SPAWN = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic             busy;
    logic [LEN_W-1:0] age;
    logic [LEN_W-1:0] len;
  } slot_cell_t;

  typedef struct packed {
    logic             shift;
    logic             tick;
    logic             load;
    logic [IDX_W-1:0] load_idx;
  } ring_ctrl_t;

  function automatic logic [OUT_SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OUT_SLOT_W-1:0] wide;
    wide = {{OUT_SLOT_W{1'b0}}, idx};
    return wide[OUT_SLOT_W-1:0];
  endfunction

  function automatic logic [OUT_CNT_W-1:0] count_field(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+OUT_CNT_W-1:0] wide;
    wide = {{OUT_CNT_W{1'b0}}, cnt};
    return wide[OUT_CNT_W-1:0];
  endfunction

endpackage

// File: rtl/core/gsa_if.sv
// valid/ready channel interfaces for spawn/tick requests and allocation results
interface gsa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [gsa_pkg::LEN_W-1:0]   grain_len;

  modport source (output valid, output cmd, output grain_len, input ready);
  modport sink   (input valid, input cmd, input grain_len, output ready);
endinterface

interface gsa_out_if;
  logic                             valid;
  logic                             ready;
  logic [gsa_pkg::OUT_SLOT_W-1:0]   slot;
  logic                             stolen;
  logic [gsa_pkg::OUT_CNT_W-1:0]    active_count;

  modport source (output valid, output slot, output stolen, output active_count, input ready);
  modport sink   (input valid, input slot, input stolen, input active_count, output ready);
endinterface

// File: rtl/core/grain_slot_allocator_unit.sv
// grain slot allocator top level: ring of slot cells around the sequencer
// Each spawn or tick request is accepted in idle and then makes one pass over all SLOTS slots,
// in which the ring of slot cells rotates by one position per cycle past the head, where the
// sequencer examines each slot (tick: ages and frees it), and then a commit, which writes the
// chosen slot on a spawn and loads the result register. The pass is the
// limiting loop. A finished result waits in its register; the next request is accepted while
// it is pending, and the commit stalls only if the previous result is still not taken.
module grain_slot_allocator_unit (
  input  logic       clk,
  input  logic       rst,
  gsa_in_if.sink     req,
  gsa_out_if.source  rsp
);

  gsa_pkg::slot_cell_t cell_q [gsa_pkg::SLOTS];
  gsa_pkg::slot_cell_t head_next;
  gsa_pkg::slot_cell_t load_val;
  gsa_pkg::ring_ctrl_t ctrl;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .head      (cell_q[0]),
    .head_next (head_next),
    .ctrl      (ctrl),
    .load_val  (load_val)
  );

  gsa_tick u_tick (
    .tick      (ctrl.tick),
    .head      (cell_q[0]),
    .head_next (head_next)
  );

  for (genvar i = 0; i < gsa_pkg::SLOTS; i++) begin : g_ring
    gsa_pkg::slot_cell_t nb;
    if (i == gsa_pkg::SLOTS - 1) begin : g_tail
      assign nb = head_next;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end

    gsa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ctrl.shift),
      .shift_in (nb),
      .load     (ctrl.load && (ctrl.load_idx == gsa_pkg::IDX_W'(i))),
      .load_val (load_val),
      .q        (cell_q[i])
    );
  end

endmodule

// File: rtl/core/gsa_cell.sv
// one slot cell of the rotating ring: busy flag, age and grain length
module gsa_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  gsa_pkg::slot_cell_t shift_in,
  input  logic                load,
  input  gsa_pkg::slot_cell_t load_val,
  output gsa_pkg::slot_cell_t q
);

  logic                      busy;
  logic [gsa_pkg::LEN_W-1:0] age;
  logic [gsa_pkg::LEN_W-1:0] len;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      age  <= '0;
    end else if (load) begin
      busy <= load_val.busy;
      age  <= load_val.age;
    end else if (shift) begin
      busy <= shift_in.busy;
      age  <= shift_in.age;
    end
  end

  // length has no reset, only read while busy
  always_ff @(posedge clk) begin
    if (load) begin
      len <= load_val.len;
    end else if (shift) begin
      len <= shift_in.len;
    end
  end

  assign q = '{busy: busy, age: age, len: len};

endmodule

// File: rtl/core/gsa_tick.sv
// aging step applied to the cell leaving the head of the ring on a tick pass
module gsa_tick (
  input  logic                tick,
  input  gsa_pkg::slot_cell_t head,
  output gsa_pkg::slot_cell_t head_next
);

  logic [gsa_pkg::LEN_W-1:0] age_inc;

  assign age_inc = head.age + gsa_pkg::LEN_W'(1);

  always_comb begin
    head_next = head;
    if (tick && head.busy) begin
      if (age_inc >= head.len) begin
        head_next.busy = 1'b0;
        head_next.age  = '0;
      end else begin
        head_next.age  = age_inc;
      end
    end
  end

endmodule

// File: rtl/core/gsa_ctrl.sv
// sequencer: walks the ring once per item, tracks free and oldest slots, holds the result
module gsa_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  gsa_in_if.sink                 req,
  gsa_out_if.source              rsp,
  input  gsa_pkg::slot_cell_t    head,
  input  gsa_pkg::slot_cell_t    head_next,
  output gsa_pkg::ring_ctrl_t    ctrl,
  output gsa_pkg::slot_cell_t    load_val
);

  gsa_pkg::state_t               state, state_next;
  logic                          cmd_q;
  logic [gsa_pkg::LEN_W-1:0]     len_q;
  logic [gsa_pkg::IDX_W-1:0]     k;
  logic [gsa_pkg::IDX_W-1:0]     ptr;
  logic                          found;
  logic [gsa_pkg::IDX_W-1:0]     best_dist;
  logic [gsa_pkg::IDX_W-1:0]     best_idx;
  logic [gsa_pkg::IDX_W-1:0]     old_idx;
  logic [gsa_pkg::LEN_W-1:0]     old_age;
  logic [gsa_pkg::CNT_W-1:0]     busy_cnt;
  logic [gsa_pkg::CNT_W-1:0]     count;
  logic                          out_valid;
  logic [gsa_pkg::OUT_SLOT_W-1:0] out_slot;
  logic                          out_stolen;
  logic [gsa_pkg::OUT_CNT_W-1:0] out_count;

  logic                          in_fire;
  logic                          out_free;
  logic                          last;
  logic                          commit;
  logic [gsa_pkg::IDX_W:0]       dist_wide;
  logic [gsa_pkg::IDX_W-1:0]     rel_pos;
  logic [gsa_pkg::IDX_W-1:0]     chosen;

  assign in_fire  = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign last     = (k == gsa_pkg::IDX_W'(gsa_pkg::SLOTS - 1));
  assign commit   = (state == gsa_pkg::ST_COMMIT) && out_free;

  // distance of slot k from the search pointer, modulo the pool size
  always_comb begin
    dist_wide = {1'b0, k} - {1'b0, ptr};
    if (k < ptr) begin
      dist_wide = dist_wide + (gsa_pkg::IDX_W + 1)'(gsa_pkg::SLOTS);
    end
    rel_pos = dist_wide[gsa_pkg::IDX_W-1:0];
  end

  assign chosen = found ? best_idx : old_idx;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gsa_pkg::ST_IDLE:   if (in_fire) state_next = gsa_pkg::ST_SCAN;
      gsa_pkg::ST_SCAN:   if (last) state_next = gsa_pkg::ST_COMMIT;
      gsa_pkg::ST_COMMIT: if (out_free) state_next = gsa_pkg::ST_IDLE;
      default:            state_next = gsa_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready     = (state == gsa_pkg::ST_IDLE);
    ctrl.shift    = (state == gsa_pkg::ST_SCAN);
    ctrl.tick     = (state == gsa_pkg::ST_SCAN) && (cmd_q == gsa_pkg::CMD_TICK);
    ctrl.load     = commit && (cmd_q == gsa_pkg::CMD_SPAWN);
    ctrl.load_idx = chosen;
  end

  assign load_val = '{busy: 1'b1, age: '0, len: len_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
        if (cmd_q == gsa_pkg::CMD_SPAWN) begin
          if (found) begin
            count <= count + gsa_pkg::CNT_W'(1);
            ptr   <= (best_idx == gsa_pkg::IDX_W'(gsa_pkg::SLOTS - 1)) ?
                     '0 : best_idx + gsa_pkg::IDX_W'(1);
          end
        end else begin
          count <= busy_cnt;
        end
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-item scan trackers and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q    <= req.cmd;
      len_q    <= req.grain_len;
      k        <= '0;
      found    <= 1'b0;
      busy_cnt <= '0;
    end else if (state == gsa_pkg::ST_SCAN) begin
      k <= k + gsa_pkg::IDX_W'(1);
      if (cmd_q == gsa_pkg::CMD_SPAWN) begin
        if (!head.busy && (!found || rel_pos < best_dist)) begin
          found     <= 1'b1;
          best_dist <= rel_pos;
          best_idx  <= k;
        end
        // strict compare keeps the lowest index on equal ages
        if (head.busy && (k == '0 || head.age > old_age)) begin
          old_idx <= k;
          old_age <= head.age;
        end
      end else if (head_next.busy) begin
        busy_cnt <= busy_cnt + gsa_pkg::CNT_W'(1);
      end
    end
    if (commit) begin
      if (cmd_q == gsa_pkg::CMD_SPAWN) begin
        out_slot   <= gsa_pkg::slot_field(chosen);
        out_stolen <= !found;
        out_count  <= gsa_pkg::count_field(found ? count + gsa_pkg::CNT_W'(1) : count);
      end else begin
        out_slot   <= '0;
        out_stolen <= 1'b0;
        out_count  <= gsa_pkg::count_field(busy_cnt);
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.slot         = out_slot;
  assign rsp.stolen       = out_stolen;
  assign rsp.active_count = out_count;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= gsa_pkg::CNT_W'(gsa_pkg::SLOTS))
    else $error("active count exceeds pool size");

  a_steal_only_full: assert property (@(posedge clk) disable iff (rst)
    (state == gsa_pkg::ST_COMMIT && cmd_q == gsa_pkg::CMD_SPAWN && !found)
      |-> count == gsa_pkg::CNT_W'(gsa_pkg::SLOTS))
    else $error("steal chosen while a slot is free");

  a_scan_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == gsa_pkg::ST_SCAN && k == '0))
    else $error("scan did not start at slot zero");

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == gsa_pkg::ST_COMMIT)
    else $error("result raised outside commit");

endmodule

// File: tb/sv/gsa_alloc_checker.sv
// checker for the grain slot allocator: predicts each result and compares output transfers
module gsa_alloc_checker
  import gsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  gsa_in_if    req,
  gsa_out_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic [OUT_SLOT_W-1:0] slot;
    logic                  stolen;
    logic [OUT_CNT_W-1:0]  active_count;
  } alloc_t;

  logic             grain_busy [SLOTS];
  logic [LEN_W-1:0] grain_age  [SLOTS];
  logic [LEN_W-1:0] grain_len  [SLOTS];
  int               rr_ptr;
  alloc_t           alloc_q [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // applies one spawn or tick to the shadow pool and returns the result it causes
  function automatic alloc_t allocate_or_age(input logic op, input logic [LEN_W-1:0] len);
    alloc_t res;
    int     chosen;
    int     p;
    int     busy_n;
    bit     found;
    chosen     = 0;
    found      = 1'b0;
    busy_n     = 0;
    res.stolen = 1'b0;
    if (op == CMD_SPAWN) begin
      for (int i = 0; i < SLOTS && !found; i++) begin
        p      = rr_ptr;
        rr_ptr = (rr_ptr + 1) % SLOTS;
        if (!grain_busy[p]) begin
          chosen = p;
          found  = 1'b1;
        end
      end
      if (!found) begin
        // full pool: oldest grain goes, lowest index wins a tie
        for (int i = 1; i < SLOTS; i++) begin
          if (grain_age[i] > grain_age[chosen]) chosen = i;
        end
        res.stolen = 1'b1;
      end
      grain_busy[chosen] = 1'b1;
      grain_age[chosen]  = '0;
      grain_len[chosen]  = len;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (grain_busy[i]) begin
          grain_age[i] = grain_age[i] + 1'b1;
          if (grain_age[i] >= grain_len[i]) begin
            grain_busy[i] = 1'b0;
            grain_age[i]  = '0;
          end
        end
      end
    end
    for (int i = 0; i < SLOTS; i++) busy_n += grain_busy[i];
    res.slot         = OUT_SLOT_W'(chosen);
    res.active_count = OUT_CNT_W'(busy_n);
    return res;
  endfunction

  always @(posedge clk) begin
    alloc_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        grain_busy[i] = 1'b0;
        grain_age[i]  = '0;
        grain_len[i]  = '0;
      end
      rr_ptr     = 0;
      fail_count = 0;
      alloc_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        alloc_q.push_back(allocate_or_age(req.cmd, req.grain_len));
      end
      if (rsp.valid && rsp.ready) begin
        if (alloc_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with none expected (slot %0d)", rsp.slot));
        end else begin
          want = alloc_q.pop_front();
          if (rsp.slot !== want.slot) begin
            report_mismatch($sformatf("slot %0d, expected %0d", rsp.slot, want.slot));
          end
          if (rsp.stolen !== want.stolen) begin
            report_mismatch($sformatf("stolen %0b, expected %0b", rsp.stolen, want.stolen));
          end
          if (rsp.active_count !== want.active_count) begin
            report_mismatch($sformatf("active_count %0d, expected %0d",
                                      rsp.active_count, want.active_count));
          end
        end
      end
    end
    pending <= alloc_q.size();
  end

endmodule

// File: tb/sv/tb_grain_slot_allocator_unit.sv
// testbench top for the grain slot allocator: clock, reset, stimulus, backpressure and verdict
module tb_grain_slot_allocator_unit;
  import gsa_pkg::*;

  localparam int RANDOM_ITEMS  = 1100;
  localparam int STEADY_ITEMS  = 120;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 20;

  typedef enum int {
    EP_TICKS,
    EP_MIX,
    EP_SPAWNS,
    EP_FILL
  } epoch_t;

  logic clk;
  logic rst;
  bit   steady_tail;
  int   fail_count;
  int   pending;

  gsa_in_if  req_ch ();
  gsa_out_if rsp_ch ();

  grain_slot_allocator_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  gsa_alloc_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 800000);
    $display("grain_slot_allocator_unit test failed");
    $finish;
  end

  // mostly short grains, with zero, the maximum and full-width values mixed in
  function automatic logic [LEN_W-1:0] pick_len(input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    if (r < 16) return LEN_W'($urandom);
    return LEN_W'($urandom_range(1, hi));
  endfunction

  // one request transfer, optionally preceded by an idle burst
  task automatic send(input logic op, input logic [LEN_W-1:0] len);
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= op;
    req_ch.grain_len <= len;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // result side backpressure
  initial begin
    int unsigned run;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (steady_tail) begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        rsp_ch.ready <= 1'b1;
        repeat (run) @(posedge clk);
        if ($urandom_range(0, 1) == 1) begin
          rsp_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    epoch_t      kind;
    int          n;
    int          k;
    int          span;
    int          spawn_pct;
    int unsigned len_hi;
    int          w;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.cmd       <= CMD_SPAWN;
    req_ch.grain_len <= '0;
    steady_tail = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero length grain frees on the next tick
    send(CMD_SPAWN, '0);
    send(CMD_TICK, '0);
    send(CMD_SPAWN, LEN_W'(1));
    send(CMD_SPAWN, LEN_W'(2));
    send(CMD_SPAWN, '1);
    send(CMD_SPAWN, LEN_W'(20'h55555));
    send(CMD_SPAWN, LEN_W'(20'hAAAAA));
    send(CMD_TICK, LEN_W'(20'h55555));
    send(CMD_TICK, '1);
    send(CMD_SPAWN, LEN_W'(3));
    send(CMD_TICK, LEN_W'(20'hAAAAA));
    send(CMD_TICK, '0);
    send(CMD_TICK, '1);
    send(CMD_SPAWN, '0);

    // epochs of differing spawn density; the first one overfills the pool
    n    = 0;
    kind = EP_FILL;
    while (n < RANDOM_ITEMS) begin
      case (kind)
        EP_TICKS: begin
          span      = $urandom_range(20, 80);
          spawn_pct = 20;
          len_hi    = 16;
        end
        EP_MIX: begin
          span      = $urandom_range(30, 100);
          spawn_pct = 50;
          len_hi    = 64;
        end
        EP_SPAWNS: begin
          span      = $urandom_range(20, 80);
          spawn_pct = 80;
          len_hi    = 400;
        end
        default: begin
          span      = SLOTS + $urandom_range(4, 30);
          spawn_pct = 100;
          len_hi    = 300;
        end
      endcase
      for (k = 0; k < span && n < RANDOM_ITEMS; k++) begin
        if (n == RANDOM_ITEMS - STEADY_ITEMS) steady_tail = 1'b1;
        if ($urandom_range(1, 100) <= spawn_pct) begin
          send(CMD_SPAWN, pick_len(len_hi));
        end else begin
          send(CMD_TICK, LEN_W'($urandom));
        end
        n++;
      end
      kind = epoch_t'($urandom_range(0, 3));
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    w = 0;
    while (pending != 0 && w < DRAIN_LIMIT) begin
      @(posedge clk);
      w++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("grain_slot_allocator_unit test passed");
    end else begin
      $display("grain_slot_allocator_unit test failed");
    end
    $finish;
  end

endmodule
